### sv/boot_control_state_machine_defines.svh
// Assertion macros shared by the checker.
`ifndef BOOT_CONTROL_STATE_MACHINE_DEFINES_SVH
`define BOOT_CONTROL_STATE_MACHINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BCSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("boot control check failed");

// Next-cycle implication, disabled during reset.
`define BCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("boot control check failed");

`endif

### sv/bcsm_pkg.sv
`timescale 1ns / 1ps

package bcsm_pkg;

    localparam int COUNTER_WIDTH = 16;
    localparam int DELAY_W       = 16;
    localparam int STATUS_W      = 16;
    localparam int OPCODE_W      = 3;
    localparam int STATE_W       = 3;
    localparam int CODE_W        = 2;
    localparam int CMP_W         = (COUNTER_WIDTH > DELAY_W) ? COUNTER_WIDTH : DELAY_W;

    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(5000);

    typedef enum logic [STATE_W-1:0] {
        ST_NO_APP    = 3'd0,
        ST_DELAY     = 3'd1,
        ST_READY     = 3'd2,
        ST_CANCELLED = 3'd3,
        ST_UPGRADING = 3'd4
    } boot_state_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK    = 3'd0,
        OP_CANCEL  = 3'd1,
        OP_REQUEST = 3'd2,
        OP_BEGIN   = 3'd3,
        OP_END     = 3'd4,
        OP_VERIFY  = 3'd5
    } op_t;

    typedef enum logic [CODE_W-1:0] {
        RC_OK        = 2'd0,
        RC_BAD_STATE = 2'd1,
        RC_ERROR     = 2'd2
    } rc_t;

    typedef struct packed {
        op_t                        opcode;
        logic signed [STATUS_W-1:0] begin_status;
        logic signed [STATUS_W-1:0] download_status;
        logic signed [STATUS_W-1:0] finalize_status;
        logic                       app_found;
    } event_t;

    typedef struct packed {
        boot_state_t                state;
        rc_t                        code;
        logic signed [STATUS_W-1:0] err;
    } step_result_t;

endpackage

### sv/bcsm_core.sv
`timescale 1ns / 1ps

module bcsm_core (
    input  bcsm_pkg::boot_state_t               cur_state,
    input  logic [bcsm_pkg::COUNTER_WIDTH-1:0]  cur_elapsed,
    input  logic [bcsm_pkg::DELAY_W-1:0]        delay_ticks,
    input  bcsm_pkg::event_t                    ev,
    output bcsm_pkg::boot_state_t               state_next,
    output logic [bcsm_pkg::COUNTER_WIDTH-1:0]  elapsed_next,
    output bcsm_pkg::step_result_t              res
);
    import bcsm_pkg::*;

    logic [COUNTER_WIDTH-1:0] elapsed_inc;
    logic                     expired;
    logic                     dl_fail;
    logic                     fin_fail;
    logic                     begin_fail;

    // saturating increment, compared after the increment
    assign elapsed_inc = (cur_elapsed == {COUNTER_WIDTH{1'b1}}) ? cur_elapsed
                                                              : cur_elapsed + 1'b1;
    assign expired     = CMP_W'(elapsed_inc) >= CMP_W'(delay_ticks);
    assign begin_fail  = ev.begin_status[STATUS_W-1];
    assign dl_fail     = ev.download_status[STATUS_W-1];
    assign fin_fail    = ev.finalize_status[STATUS_W-1];

    // next state and counter
    always_comb
    begin
        state_next   = cur_state;
        elapsed_next = cur_elapsed;
        unique case (ev.opcode)
            OP_TICK:
            begin
                if (cur_state == ST_DELAY)
                begin
                    elapsed_next = elapsed_inc;
                    if (expired)
                    begin
                        state_next = ST_READY;
                    end
                end
            end
            OP_CANCEL:
            begin
                if (cur_state == ST_DELAY || cur_state == ST_READY)
                begin
                    state_next = ST_CANCELLED;
                end
            end
            OP_REQUEST:
            begin
                if (cur_state == ST_DELAY || cur_state == ST_CANCELLED)
                begin
                    state_next = ST_READY;
                end
            end
            OP_BEGIN:
            begin
                // a failed begin still leaves the upgrade state set
                if (cur_state != ST_READY && cur_state != ST_UPGRADING)
                begin
                    state_next = ST_UPGRADING;
                end
            end
            OP_END:
            begin
                if (cur_state == ST_UPGRADING)
                begin
                    state_next = ST_NO_APP;
                    if (!dl_fail && !fin_fail && ev.app_found)
                    begin
                        state_next   = ST_DELAY;
                        elapsed_next = '0;
                    end
                end
            end
            OP_VERIFY:
            begin
                if (ev.app_found)
                begin
                    state_next   = ST_DELAY;
                    elapsed_next = '0;
                end
                else
                begin
                    state_next = ST_NO_APP;
                end
            end
            default:
            begin
                state_next = cur_state;
            end
        endcase
    end

    // status code and passed-through error
    always_comb
    begin
        res.state = state_next;
        res.code  = RC_OK;
        res.err   = '0;
        unique case (ev.opcode)
            OP_BEGIN:
            begin
                if (cur_state == ST_READY || cur_state == ST_UPGRADING)
                begin
                    res.code = RC_BAD_STATE;
                end
                else if (begin_fail)
                begin
                    res.code = RC_ERROR;
                    res.err  = ev.begin_status;
                end
            end
            OP_END:
            begin
                if (cur_state != ST_UPGRADING)
                begin
                    res.code = RC_BAD_STATE;
                end
                else if (dl_fail)
                begin
                    res.code = RC_ERROR;
                    res.err  = ev.download_status;
                end
                else if (fin_fail)
                begin
                    res.code = RC_ERROR;
                    res.err  = ev.finalize_status;
                end
            end
            default:
            begin
                res.code = RC_OK;
            end
        endcase
    end

endmodule

### sv/boot_control_state_machine.sv
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// in       in_valid / in_ready   opcode, begin_status, download_status,
//                                finalize_status, app_found
// out      out_valid / out_ready boot_state_out, result_code, error_value
// cfg      cfg_valid / cfg_ready cfg_data (boot delay ticks)
//
// One event per cycle sustained while out_ready is high; an accepted event
// passes the input register, then the state update into the result register.
// The state and tick counter update in the same cycle the event moves to the
// result register, so back-to-back events see each other's effect.
// Reset: no app, count zero, delay 5000 ticks; both pipeline stages empty.
// A stalled result holds the input register, and in_ready drops only when both
// stages are full.

module boot_control_state_machine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bcsm_pkg::OPCODE_W-1:0]        opcode,
    input  logic signed [bcsm_pkg::STATUS_W-1:0] begin_status,
    input  logic signed [bcsm_pkg::STATUS_W-1:0] download_status,
    input  logic signed [bcsm_pkg::STATUS_W-1:0] finalize_status,
    input  logic                                 app_found,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bcsm_pkg::STATE_W-1:0]         boot_state_out,
    output logic [bcsm_pkg::CODE_W-1:0]          result_code,
    output logic signed [bcsm_pkg::STATUS_W-1:0] error_value,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bcsm_pkg::DELAY_W-1:0]         cfg_data
);
    import bcsm_pkg::*;

    logic                     ev_valid_reg;
    event_t                   ev_reg;
    logic                     out_valid_reg;
    step_result_t             res_reg;
    boot_state_t              boot_state_reg;
    logic [COUNTER_WIDTH-1:0] elapsed_reg;
    logic [DELAY_W-1:0]       delay_reg;

    boot_state_t              boot_state_next;
    logic [COUNTER_WIDTH-1:0] elapsed_next;
    step_result_t             res_next;
    logic                     advance;

    assign advance   = ev_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !ev_valid_reg || advance;
    assign cfg_ready = 1'b1;

    bcsm_core u_core (
        .cur_state    (boot_state_reg),
        .cur_elapsed  (elapsed_reg),
        .delay_ticks  (delay_reg),
        .ev           (ev_reg),
        .state_next   (boot_state_next),
        .elapsed_next (elapsed_next),
        .res          (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            boot_state_reg <= ST_NO_APP;
            elapsed_reg    <= '0;
            delay_reg      <= DELAY_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                ev_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                boot_state_reg <= boot_state_next;
                elapsed_reg    <= elapsed_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                delay_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ev_reg.opcode          <= op_t'(opcode);
            ev_reg.begin_status    <= begin_status;
            ev_reg.download_status <= download_status;
            ev_reg.finalize_status <= finalize_status;
            ev_reg.app_found       <= app_found;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign boot_state_out = res_reg.state;
    assign result_code    = res_reg.code;
    assign error_value    = res_reg.err;

endmodule

### sv/bcsm_checker.sv
`timescale 1ns / 1ps
`include "boot_control_state_machine_defines.svh"

module bcsm_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [bcsm_pkg::STATE_W-1:0]         boot_state_out,
    input logic [bcsm_pkg::CODE_W-1:0]          result_code,
    input logic signed [bcsm_pkg::STATUS_W-1:0] error_value
);
    import bcsm_pkg::*;

    // a pending result is not withdrawn
    `BCSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // error value only travels with an error code
    `BCSM_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && result_code != RC_ERROR, error_value == '0)

    // a passed-through error is always negative
    `BCSM_ASSERT_NOW(a_err_neg, clk, rst_n, out_valid && result_code == RC_ERROR, error_value[STATUS_W-1])

    // errors come only from begin (leaves upgrading) or end (leaves no app)
    `BCSM_ASSERT_NOW(a_err_state, clk, rst_n, out_valid && result_code == RC_ERROR, boot_state_out == ST_UPGRADING || boot_state_out == ST_NO_APP)

endmodule

bind boot_control_state_machine bcsm_checker u_bcsm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .boot_state_out (boot_state_out),
    .result_code    (result_code),
    .error_value    (error_value)
);
